/* rtl/core/itrd_pkg.sv */
// Shared constants and helpers for the integer-to-radix digit unit.
package itrd_pkg;

   localparam int VALUE_BITS_DEFAULT = 31;
   localparam int RADIX_W            = 6;
   localparam int CHAR_W             = 7;

   localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
   localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

   localparam logic [RADIX_W-1:0] DIGIT_NINE = 6'd9;
   localparam logic [RADIX_W-1:0] DIGIT_TEN  = 6'd10;
   localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 7'h30;
   localparam logic [CHAR_W-1:0]  CHAR_ALPHA = 7'h41;

   // Clamp a written base into the supported range.
   function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
      logic [RADIX_W-1:0] res;
      res = r;
      if (r < RADIX_MIN) begin
         res = RADIX_MIN;
      end else if (r > RADIX_MAX) begin
         res = RADIX_MAX;
      end
      return res;
   endfunction

   // Map a digit value to its ASCII character.
   function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
      logic [CHAR_W-1:0] res;
      if (d <= DIGIT_NINE) begin
         res = CHAR_ZERO + CHAR_W'(d);
      end else begin
         res = CHAR_ALPHA + CHAR_W'(d - DIGIT_TEN);
      end
      return res;
   endfunction

endpackage

/* rtl/core/itrd_front.sv */
// Front stage: base register, input acceptance and zero-key filtering.
module itrd_front #(
   parameter int VALUE_BITS = itrd_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [itrd_pkg::RADIX_W-1:0] csr_radix,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic [VALUE_BITS-1:0]        req_value,
   output logic                         q_push,
   input  logic                         q_full,
   output logic [VALUE_BITS-1:0]        q_value,
   output logic [itrd_pkg::RADIX_W-1:0] q_radix
);

   logic [itrd_pkg::RADIX_W-1:0] radix_ff, radix_in;
   logic                         stage_valid_ff, stage_valid_in;
   logic [VALUE_BITS-1:0]        stage_value_ff;
   logic [itrd_pkg::RADIX_W-1:0] stage_radix_ff;
   logic                         accept;
   logic                         move;

   assign csr_ready = 1'b1;
   assign move      = stage_valid_ff && !q_full;
   assign req_full  = stage_valid_ff && q_full;
   assign accept    = req_push && !req_full;
   assign q_push    = stage_valid_ff;
   assign q_value   = stage_value_ff;
   assign q_radix   = stage_radix_ff;

   always_comb begin
      radix_in = radix_ff;
      if (csr_valid) begin
         radix_in = csr_radix;
      end
      stage_valid_in = stage_valid_ff;
      if (accept) begin
         // drop a zero key: it has no digits
         stage_valid_in = (req_value != '0);
      end else if (move) begin
         stage_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff       <= itrd_pkg::RADIX_RESET;
         stage_valid_ff <= 1'b0;
      end else begin
         radix_ff       <= radix_in;
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_value_ff <= req_value;
         stage_radix_ff <= itrd_pkg::clamp_radix(radix_ff);
      end
   end

endmodule

/* rtl/core/itrd_queue.sv */
// Two-entry queue between the front and back stages.
module itrd_queue #(
   parameter int WIDTH = itrd_pkg::VALUE_BITS_DEFAULT + itrd_pkg::RADIX_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

/* rtl/core/itrd_back.sv */
// Back stage: bit-serial divider, digit memory and output register.
module itrd_back #(
   parameter int VALUE_BITS = itrd_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_empty,
   output logic                         q_pop,
   input  logic [VALUE_BITS-1:0]        q_value,
   input  logic [itrd_pkg::RADIX_W-1:0] q_radix,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output logic [itrd_pkg::CHAR_W-1:0]  rsp_digit_char,
   output logic                         rsp_last
);

   localparam int BIT_W = $clog2(VALUE_BITS);
   localparam int CNT_W = $clog2(VALUE_BITS + 1);
   localparam int MEM_DEPTH = 2 ** CNT_W;
   localparam logic [BIT_W-1:0] BIT_MAX = BIT_W'(VALUE_BITS - 1);
   localparam int RW = itrd_pkg::RADIX_W;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [VALUE_BITS-1:0] quo_ff, quo_in;
   logic [RW-1:0]         rem_ff, rem_in;
   logic [RW-1:0]         radix_ff, radix_in;
   logic [BIT_W-1:0]      bit_ff, bit_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [CNT_W-1:0]      emit_idx_ff, emit_idx_in;
   logic                  rd_pend_ff, rd_pend_in;
   logic                  rd_last_ff;
   logic [RW-1:0]         rd_digit_ff;
   logic                  out_valid_ff, out_valid_in;
   logic [itrd_pkg::CHAR_W-1:0] out_char_ff;
   logic                  out_last_ff;

   logic [RW-1:0]         digit_mem [MEM_DEPTH];

   logic [RW:0]           trial;
   logic                  ge;
   logic [RW-1:0]         rem_step;
   logic [VALUE_BITS-1:0] quo_step;
   logic                  div_done;
   logic                  xfer;
   logic                  issue;

   assign trial    = {rem_ff, quo_ff[VALUE_BITS-1]};
   assign ge       = (trial >= {1'b0, radix_ff});
   assign rem_step = ge ? RW'(trial - {1'b0, radix_ff}) : trial[RW-1:0];
   assign quo_step = {quo_ff[VALUE_BITS-2:0], ge};
   assign div_done = (state_ff == ST_DIV) && (bit_ff == '0);

   assign xfer  = rd_pend_ff && (!out_valid_ff || rsp_pop);
   assign issue = (state_ff == ST_EMIT) && (!rd_pend_ff || xfer);

   assign rsp_empty      = !out_valid_ff;
   assign rsp_digit_char = out_char_ff;
   assign rsp_last       = out_last_ff;

   always_comb begin
      state_in    = state_ff;
      quo_in      = quo_ff;
      rem_in      = rem_ff;
      radix_in    = radix_ff;
      bit_in      = bit_ff;
      cnt_in      = cnt_ff;
      emit_idx_in = emit_idx_ff;
      q_pop       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               quo_in   = q_value;
               radix_in = q_radix;
               rem_in   = '0;
               bit_in   = BIT_MAX;
               cnt_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            quo_in = quo_step;
            rem_in = rem_step;
            bit_in = bit_ff - BIT_W'(1);
            if (bit_ff == '0) begin
               rem_in = '0;
               bit_in = BIT_MAX;
               if (quo_step == '0) begin
                  emit_idx_in = cnt_ff;
                  state_in    = ST_EMIT;
               end else begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end
            end
         end
         ST_EMIT: begin
            if (issue) begin
               emit_idx_in = emit_idx_ff - CNT_W'(1);
               if (emit_idx_ff == '0) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rd_pend_in = rd_pend_ff;
      if (issue) begin
         rd_pend_in = 1'b1;
      end else if (xfer) begin
         rd_pend_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (xfer) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_pend_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_pend_ff   <= rd_pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      radix_ff    <= radix_in;
      bit_ff      <= bit_in;
      cnt_ff      <= cnt_in;
      emit_idx_ff <= emit_idx_in;
   end

   // digit memory: written least significant first, read back in reverse
   always_ff @(posedge clock) begin
      if (div_done) begin
         digit_mem[cnt_ff] <= rem_step;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_digit_ff <= digit_mem[emit_idx_ff];
         rd_last_ff  <= (emit_idx_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (xfer) begin
         out_char_ff <= itrd_pkg::digit_to_ascii(rd_digit_ff);
         out_last_ff <= rd_last_ff;
      end
   end

   a_rem_below_radix: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < radix_ff))
      else $error("remainder not below base during division");

   a_radix_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (radix_ff >= itrd_pkg::RADIX_MIN &&
                                 radix_ff <= itrd_pkg::RADIX_MAX))
      else $error("base out of range in back stage");

   a_emit_idx_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (emit_idx_ff < CNT_W'(VALUE_BITS)))
      else $error("digit index beyond key width");

   a_char_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_char_ff >= 7'd48 && out_char_ff <= 7'd90))
      else $error("output character outside 0-9, A-Z");

endmodule

/* rtl/core/integer_to_radix_digits_unit.sv */
// Top level of the integer-to-radix digit conversion unit.
//
// Usage:
//   req_  : input queue port. A key word is taken when req_push is high and
//           req_full is low. A zero key is taken and dropped (no digits).
//   rsp_  : output queue port. While rsp_empty is low the oldest digit word
//           sits on rsp_digit_char/rsp_last; pop it with rsp_pop. Digits come
//           most significant first; rsp_last marks the least significant one.
//   csr_  : base register write port, always ready. Write only while idle;
//           values below 2 or above 36 act as 2 or 36. Reset value is 10.
//   Path:   the front register, then the queue, then one pass of the shared
//           bit-serial divider per digit, then the digit read register and
//           the output register.
//   Flow:   a key is divided, then its digits go out one digit per cycle
//           while rsp_pop is high; the next key starts after its last digit.
//   Reset (synchronous, active high) empties the front stage, the queue and
//   the output register and sets the base to 10. No clearing pass is needed.
//   A stalled receiver holds the output word; the read-out stops, then the
//   queue and front register fill and req_full rises.
module integer_to_radix_digits_unit #(
   parameter int VALUE_BITS = itrd_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic [VALUE_BITS-1:0]        req_value,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output logic [itrd_pkg::CHAR_W-1:0]  rsp_digit_char,
   output logic                         rsp_last,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [itrd_pkg::RADIX_W-1:0] csr_radix
);

   localparam int Q_W = VALUE_BITS + itrd_pkg::RADIX_W;

   // front to queue
   logic                         fq_push;
   logic                         fq_full;
   logic [VALUE_BITS-1:0]        fq_value;
   logic [itrd_pkg::RADIX_W-1:0] fq_radix;

   // queue to back
   logic                         qb_pop;
   logic                         qb_empty;
   logic [Q_W-1:0]               qb_word;

   // accept keys, hold the base register, drop zero keys
   itrd_front #(
      .VALUE_BITS(VALUE_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_radix (csr_radix),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_value (req_value),
      .q_push    (fq_push),
      .q_full    (fq_full),
      .q_value   (fq_value),
      .q_radix   (fq_radix)
   );

   // decouple the front from the long-running divider
   itrd_queue #(
      .WIDTH(Q_W)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (fq_push),
      .wdata ({fq_radix, fq_value}),
      .full  (fq_full),
      .pop   (qb_pop),
      .rdata (qb_word),
      .empty (qb_empty)
   );

   // divide, store digits, then replay them most significant first
   itrd_back #(
      .VALUE_BITS(VALUE_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (qb_empty),
      .q_pop          (qb_pop),
      .q_value        (qb_word[VALUE_BITS-1:0]),
      .q_radix        (qb_word[Q_W-1:VALUE_BITS]),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last       (rsp_last)
   );

endmodule

/* dv/itrd_digit_checker.sv */
// Port monitor and digit predictor for the integer-to-radix digit unit.
`timescale 1ns / 1ps
module itrd_digit_checker
   import itrd_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   input  logic                  req_full,
   input  logic [VALUE_BITS-1:0] req_value,
   input  logic                  rsp_empty,
   input  logic                  rsp_pop,
   input  logic [CHAR_W-1:0]     rsp_digit_char,
   input  logic                  rsp_last,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [RADIX_W-1:0]    csr_radix,
   output int                    fail_count,
   output int                    words_due,
   output int                    keys_taken,
   output int                    words_checked
);

   typedef struct packed {
      logic [CHAR_W-1:0] digit_char;
      logic              last;
   } digit_word_t;

   digit_word_t        digits_due_q[$];
   logic [RADIX_W-1:0] radix_reg = RADIX_RESET;
   int                 n_fail    = 0;
   int                 n_keys    = 0;
   int                 n_words   = 0;

   always @(posedge clock) begin : watch
      logic [RADIX_W-1:0] base;
      logic [RADIX_W-1:0] lsd_first[$];
      longint unsigned    rest;
      digit_word_t        want;
      digit_word_t        got;

      if (reset) begin
         digits_due_q.delete();
         radix_reg = RADIX_RESET;
      end else begin
         // Retire the word leaving the unit before queueing new digits.
         if (rsp_pop && !rsp_empty) begin
            got.digit_char = rsp_digit_char;
            got.last       = rsp_last;
            n_words++;
            if (digits_due_q.size() == 0) begin
               n_fail++;
               if (n_fail <= 10)
                  $display("[%0t] unexpected digit word: char %h last %0b",
                           $time, got.digit_char, got.last);
            end else begin
               want = digits_due_q.pop_front();
               if (got.digit_char !== want.digit_char || got.last !== want.last) begin
                  n_fail++;
                  if (n_fail <= 10)
                     $display("[%0t] digit word %0d mismatch: expected char %h last %0b, got char %h last %0b",
                              $time, n_words, want.digit_char, want.last,
                              got.digit_char, got.last);
               end
            end
         end

         if (csr_valid && csr_ready)
            radix_reg = csr_radix;

         // Divide down to zero, then emit most significant digit first.
         if (req_push && !req_full) begin
            n_keys++;
            base = radix_reg;
            if (base < RADIX_MIN)
               base = RADIX_MIN;
            else if (base > RADIX_MAX)
               base = RADIX_MAX;
            lsd_first.delete();
            rest = req_value;
            while (rest != 0) begin
               lsd_first.push_back(RADIX_W'(rest % base));
               rest = rest / base;
            end
            for (int k = lsd_first.size() - 1; k >= 0; k--) begin
               if (lsd_first[k] <= DIGIT_NINE)
                  want.digit_char = CHAR_ZERO + CHAR_W'(lsd_first[k]);
               else
                  want.digit_char = CHAR_ALPHA + CHAR_W'(lsd_first[k] - DIGIT_TEN);
               want.last = (k == 0);
               digits_due_q.push_back(want);
            end
         end
      end

      fail_count    <= n_fail;
      words_due     <= digits_due_q.size();
      keys_taken    <= n_keys;
      words_checked <= n_words;
   end

endmodule

/* dv/testbench.sv */
// Stimulus, clocking and verdict for the integer-to-radix digit unit.
`timescale 1ns / 1ps
module testbench;
   import itrd_pkg::*;

   localparam int VALUE_BITS      = VALUE_BITS_DEFAULT;
   // Extra wait after the last digit word; zero keys are dropped at the front.
   localparam int SETTLE_CYCLES   = 2 * VALUE_BITS + 16;
   localparam int HOLD_OFF_CYCLES = 3000;
   localparam int RANDOM_PHASES   = 10;
   localparam int KEYS_PER_PHASE  = 20;
   localparam int N_DIRECTED      = 21;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_push   = 1'b0;
   logic                  req_full;
   logic [VALUE_BITS-1:0] req_value  = '0;
   logic                  rsp_empty;
   logic                  rsp_pop    = 1'b0;
   logic [CHAR_W-1:0]     rsp_digit_char;
   logic                  rsp_last;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [RADIX_W-1:0]    csr_radix  = '0;

   int fail_count;
   int words_due;
   int keys_taken;
   int words_checked;

   // Tracks the base last written so keys can be shaped around its powers.
   int cur_radix     = RADIX_RESET;
   int radix_writes  = 0;
   int full_cycles   = 0;
   bit hold_off_req  = 1'b0;
   bit holding       = 1'b0;

   // Directed keys; a base of -1 keeps the current setting.
   int directed_radix [N_DIRECTED] = '{
      -1, -1, -1, -1, -1, -1,
       2, -1, -1, -1, -1,
      36, -1, -1, -1,
       0, 63, -1,  1, 37, 16
   };
   logic [VALUE_BITS-1:0] directed_key [N_DIRECTED] = '{
      0, 1, 9, 10, 2147483647, 1000000000,
      1, 2, 2147483647, 1073741824, 715827882,
      35, 36, 2147483647, 1295,
      6, 35, 71, 3, 36, 180150000
   };
   int extremes [4] = '{63, 1, 36, 2};

   integer_to_radix_digits_unit #(
      .VALUE_BITS(VALUE_BITS)
   ) u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_value     (req_value),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_digit_char(rsp_digit_char),
      .rsp_last      (rsp_last),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_radix     (csr_radix)
   );

   itrd_digit_checker #(
      .VALUE_BITS(VALUE_BITS)
   ) u_check (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_value     (req_value),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_digit_char(rsp_digit_char),
      .rsp_last      (rsp_last),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_radix     (csr_radix),
      .fail_count    (fail_count),
      .words_due     (words_due),
      .keys_taken    (keys_taken),
      .words_checked (words_checked)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop in case the unit hangs; far beyond the slowest legal run.
   initial begin
      #200_000_000;
      $display("[integer_to_radix_digits_unit] ERROR");
      $finish;
   end

   // Count cycles where a key word is offered but the unit pushes back.
   always @(posedge clock) begin
      if (!reset && req_push && req_full)
         full_cycles <= full_cycles + 1;
   end

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      if (roll < 95)
         return $urandom_range(1, 4);
      return $urandom_range(30, 200);
   endfunction

   // Mix small keys, full-width noise, all ones, powers of the base and
   // their neighbors, single bits and the odd zero key.
   function automatic logic [VALUE_BITS-1:0] pick_key(input int r);
      int unsigned     roll;
      int unsigned     base;
      int unsigned     steps;
      longint unsigned pw;
      roll = $urandom_range(0, 19);
      base = (r < 2) ? 2 : ((r > 36) ? 36 : r);
      if (roll == 0)
         return '0;
      if (roll < 6)
         return VALUE_BITS'($urandom_range(1, base * base * base));
      if (roll < 13)
         return VALUE_BITS'($urandom());
      if (roll == 13)
         return '1;
      if (roll < 17) begin
         pw    = base;
         steps = $urandom_range(0, 30);
         while (steps > 0 && pw * base < (64'd1 << VALUE_BITS)) begin
            pw = pw * base;
            steps--;
         end
         return VALUE_BITS'(pw - $urandom_range(0, 1));
      end
      return VALUE_BITS'(1) << $urandom_range(0, VALUE_BITS - 1);
   endfunction

   // Offer one key word and hold it until the unit takes it. Leave push
   // high on return so back-to-back words need no extra assignment.
   task automatic send_key(input logic [VALUE_BITS-1:0] key, input bit steady);
      int unsigned gap;
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push  <= 1'b1;
      req_value <= key;
      do
         @(posedge clock);
      while (req_full);
   endtask

   // Drop push, wait for every digit word to come back plus a settle time,
   // then write the base register.
   task automatic write_radix(input int r);
      req_push <= 1'b0;
      repeat (2) @(posedge clock);
      while (words_due != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_radix <= RADIX_W'(r);
      do
         @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      cur_radix = r;
      radix_writes++;
   endtask

   // Receiver: bursts of pops separated by random gaps. Once the sender
   // asks for it, stop popping for a long stretch so the unit backs up
   // and raises full.
   initial begin : drain
      int unsigned burst;
      int unsigned gap;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            holding      = 1'b1;
            rsp_pop <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            holding = 1'b0;
         end
         burst = $urandom_range(1, 40);
         rsp_pop <= 1'b1;
         repeat (burst) @(posedge clock);
         gap = pick_gap();
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed pass: field extremes, a maximal run of base-2 digits,
      // the top letter, bases clamped from below and above.
      for (int i = 0; i < N_DIRECTED; i++) begin
         if (directed_radix[i] >= 0)
            write_radix(directed_radix[i]);
         send_key(directed_key[i], 1'b0);
      end

      // Random pass: the first phases revisit the clamp edges, the rest
      // pick any 6-bit base. Every third phase runs without sender gaps.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         write_radix(phase < 4 ? extremes[phase] : int'($urandom_range(0, 63)));
         for (int i = 0; i < KEYS_PER_PHASE; i++) begin
            if (phase == 5 && i == 4)
               hold_off_req = 1'b1;
            send_key(pick_key(cur_radix),
                     (phase % 3 == 2) || hold_off_req || holding);
         end
      end

      // Drain: wait for the last digit word, then let the pipe settle.
      req_push <= 1'b0;
      repeat (2) @(posedge clock);
      while (words_due != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Coverage: %0d keys in, %0d digit words checked, %0d base writes.",
               keys_taken, words_checked, radix_writes);
      $display("Back-pressure: input held off by full for %0d cycles.", full_cycles);
      if (fail_count == 0 && words_due == 0) begin
         $display("[integer_to_radix_digits_unit] OK");
      end else begin
         $display("[integer_to_radix_digits_unit] ERROR");
      end
      $finish;
   end

endmodule
